/* design/psc_pkg.sv */
// Package for the patch slot cache: shared types, constants and the LFSR step.
// No dependencies; imported by every module of the block.
package psc_pkg;

  // LFSR reset value, also used when a zero seed is written
  localparam logic [15:0] SEED_RESET = 16'd44257;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_VICTIM,
    ST_SEARCH,
    ST_DONE
  } psc_state_e;

  // Contents of one slot cell: x in bits 15..0, y in bits 31..16
  typedef struct packed {
    logic        valid;
    logic [31:0] coords;
  } cell_data_t;

  // Commands from the controller to the victim unit
  typedef struct packed {
    logic start;
    logic commit;
  } vic_ctrl_t;

  // Fibonacci LFSR, taps 16,14,13,11, shifting right
  function automatic logic [15:0] lfsr_next(input logic [15:0] s);
    logic fb;
    fb = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {fb, s[15:1]};
  endfunction

endpackage

/* design/patch_slot_cache_random_replace_core.sv */
// Patch slot cache, random replacement: ring of NUM_LAYERS slot cells and controller.
// Each request computes the victim remainder, then takes one full lap of the slot ring
// past the compare point, then finishes and installs; a waiting result holds the finish.
// A new request is accepted only once the previous one has finished.
// Reset clears all slot valid bits and loads the LFSR with 44257; slot keys are unset.
module patch_slot_cache_random_replace_core
  import psc_pkg::*;
#(
  parameter int NUM_LAYERS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] patch_x_i,
  input  logic [15:0] patch_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  slot_index_o,
  output logic        was_miss_o,
  output logic        evicted_valid_o,
  output logic [15:0] evicted_x_o,
  output logic [15:0] evicted_y_o
);

  localparam int IW = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
  localparam logic [IW-1:0] LAST = IW'(NUM_LAYERS - 1);

  psc_state_e  state_q, state_d;
  logic [31:0] key_q;
  logic [IW-1:0] cnt_q;
  logic        hit_q;
  logic [IW-1:0] hit_idx_q;
  logic        ev_valid_q;
  logic [31:0] ev_coords_q;
  logic        out_valid_q;

  logic        in_fire;
  logic        shift;
  logic        finish;
  logic        install;
  vic_ctrl_t   vic_ctrl;
  logic        vic_done;
  logic [IW-1:0] vic_idx;
  logic [IW-1:0] res_idx;
  logic [IW+7:0] res_idx_ext;
  cell_data_t  cells [NUM_LAYERS];
  cell_data_t  head;

  assign in_fire = in_valid_i && in_ready_o;
  assign head    = cells[0];

  // Victim unit
  psc_victim #(
    .NUM_LAYERS(NUM_LAYERS)
  ) u_victim (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .ctrl_i     (vic_ctrl),
    .done_o     (vic_done),
    .vic_idx_o  (vic_idx)
  );

  // Ring of slot cells; each cell takes its upper neighbor on a shift
  for (genvar i = 0; i < NUM_LAYERS; i++) begin : g_cell
    psc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (shift),
      .wr_i       (install && (vic_idx == IW'(i))),
      .wr_coords_i(key_q),
      .nbr_i      (cells[(i + 1) % NUM_LAYERS]),
      .data_o     (cells[i])
    );
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and controls
  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    shift           = 1'b0;
    finish          = 1'b0;
    vic_ctrl.start  = 1'b0;
    vic_ctrl.commit = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          vic_ctrl.start = 1'b1;
          state_d        = ST_VICTIM;
        end
      end
      ST_VICTIM: begin
        if (vic_done) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        shift = 1'b1;
        if (cnt_q == LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          finish          = 1'b1;
          vic_ctrl.commit = !hit_q;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign install = finish && !hit_q;

  // Capture the request key
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      key_q <= {patch_y_i, patch_x_i};
    end
  end

  // Compare the slot at the head of the ring; note the first hit and the victim's old key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      hit_q      <= 1'b0;
      ev_valid_q <= 1'b0;
    end else if (in_fire) begin
      cnt_q      <= '0;
      hit_q      <= 1'b0;
      ev_valid_q <= 1'b0;
    end else if (shift) begin
      cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + IW'(1);
      if (!hit_q && head.valid && (head.coords == key_q)) begin
        hit_q <= 1'b1;
      end
      if (cnt_q == vic_idx) begin
        ev_valid_q <= head.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      if (!hit_q && head.valid && (head.coords == key_q)) begin
        hit_idx_q <= cnt_q;
      end
      if (cnt_q == vic_idx) begin
        ev_coords_q <= head.coords;
      end
    end
  end

  assign res_idx     = hit_q ? hit_idx_q : vic_idx;
  assign res_idx_ext = {8'd0, res_idx};

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (finish) begin
      slot_index_o    <= res_idx_ext[7:0];
      was_miss_o      <= !hit_q;
      evicted_valid_o <= !hit_q && ev_valid_q;
      evicted_x_o     <= (!hit_q && ev_valid_q) ? ev_coords_q[15:0]  : 16'd0;
      evicted_y_o     <= (!hit_q && ev_valid_q) ? ev_coords_q[31:16] : 16'd0;
    end
  end

  assign out_valid_o = out_valid_q;

  // A request always starts with the victim computation
  a_start_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_VICTIM))
    else $error("accepted request did not start victim selection");

  // The ring lap ends after the last slot
  a_lap_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) && (cnt_q == LAST) |=> (state_q == ST_DONE) && (cnt_q == '0))
    else $error("slot ring lap did not end at the last slot");

  // A hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !was_miss_o |-> !evicted_valid_o)
    else $error("eviction reported on a hit");

endmodule

/* design/psc_cell.sv */
// One slot cell of the rotating slot ring: holds a valid bit and a coordinate key.
// Depends on psc_pkg for cell_data_t.
module psc_cell
  import psc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        shift_i,
  input  logic        wr_i,
  input  logic [31:0] wr_coords_i,
  input  cell_data_t  nbr_i,
  output cell_data_t  data_o
);

  logic        valid_q;
  logic [31:0] coords_q;

  // Take the neighbor's valid bit on a shift, set it on an install
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= nbr_i.valid;
    end else if (wr_i) begin
      valid_q <= 1'b1;
    end
  end

  // Move or install the key; no reset needed
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      coords_q <= nbr_i.coords;
    end else if (wr_i) begin
      coords_q <= wr_coords_i;
    end
  end

  assign data_o.valid  = valid_q;
  assign data_o.coords = coords_q;

endmodule

/* design/psc_victim.sv */
// Victim selection: seed-loaded LFSR and a remainder by NUM_LAYERS by reciprocal multiply.
// Depends on psc_pkg for lfsr_next, SEED_RESET and vic_ctrl_t.
module psc_victim
  import psc_pkg::*;
#(
  parameter int NUM_LAYERS = 256,
  localparam int IW = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  input  vic_ctrl_t     ctrl_i,
  output logic          done_o,
  output logic [IW-1:0] vic_idx_o
);

  // 2^32 / NUM_LAYERS rounded down, plus one; the quotient is exact for every 16-bit value
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(NUM_LAYERS) + 64'd1);
  localparam logic [15:0] NV    = 16'(NUM_LAYERS);

  logic [15:0]   lfsr_q;
  logic [15:0]   lfsr_nxt;
  logic [47:0]   quot_prod;
  logic [15:0]   quot_q;
  logic [15:0]   quot_mul;
  logic [15:0]   rem_full;
  logic [IW-1:0] rem_q;
  logic          busy_q;

  assign lfsr_nxt = lfsr_next(lfsr_q);

  // Hold the LFSR; load on a seed write, advance when a miss commits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= SEED_RESET;
    end else if (cfg_we_i) begin
      lfsr_q <= (cfg_wdata_i == 16'd0) ? SEED_RESET : cfg_wdata_i;
    end else if (ctrl_i.commit) begin
      lfsr_q <= lfsr_nxt;
    end
  end

  // Quotient of the next LFSR value, then remainder from quotient times NUM_LAYERS
  assign quot_prod = {32'd0, lfsr_nxt} * {16'd0, RECIP};
  assign quot_mul  = quot_q * NV;
  assign rem_full  = lfsr_nxt - quot_mul;

  // Register the quotient on start and the remainder in the following cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      quot_q <= '0;
      rem_q  <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      quot_q <= quot_prod[47:32];
    end else if (busy_q) begin
      busy_q <= 1'b0;
      rem_q  <= rem_full[IW-1:0];
    end
  end

  assign done_o    = !busy_q;
  assign vic_idx_o = rem_q;

endmodule

/* verif/tb_patch_slot_cache_random_replace_core.sv */
// Testbench for the patch slot cache core: directed and random patch lookups with
// backpressure and seed writes, each result checked against a built-in cache predictor.
// Depends on psc_pkg and patch_slot_cache_random_replace_core.
module tb_patch_slot_cache_random_replace_core
  import psc_pkg::*;
();

  localparam int NUM_LAYERS   = 256;
  localparam int POOL_MAX     = 1024;
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 2_500_000;

  typedef struct packed {
    logic [7:0]  slot_index;
    logic        was_miss;
    logic        evicted_valid;
    logic [15:0] evicted_x;
    logic [15:0] evicted_y;
  } slot_result_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = 16'h0000;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [15:0] patch_x_i   = 16'h0000;
  logic [15:0] patch_y_i   = 16'h0000;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  slot_index_o;
  logic        was_miss_o;
  logic        evicted_valid_o;
  logic [15:0] evicted_x_o;
  logic [15:0] evicted_y_o;

  // Predictor state: slot tags, valid bits and victim LFSR
  logic        slot_filled [NUM_LAYERS];
  logic [31:0] slot_tag    [NUM_LAYERS];
  logic [15:0] victim_state;

  slot_result_t expected_slot_results[$];
  logic [31:0]  key_pool[POOL_MAX];

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned result_count   = 0;
  int          rx_hold_left   = 0;
  int          rx_stall_left  = 0;
  bit          rx_stalls_on   = 1'b1;
  bit          tx_gaps_on     = 1'b1;

  patch_slot_cache_random_replace_core #(
    .NUM_LAYERS(NUM_LAYERS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .patch_x_i      (patch_x_i),
    .patch_y_i      (patch_y_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .slot_index_o   (slot_index_o),
    .was_miss_o     (was_miss_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_x_o    (evicted_x_o),
    .evicted_y_o    (evicted_y_o)
  );

  always #1 clk_i = ~clk_i;

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Step the victim LFSR: Fibonacci, taps 16,14,13,11, shift right
  function automatic logic [15:0] step_victim_lfsr(input logic [15:0] s);
    logic feedback;
    feedback = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {feedback, s[15:1]};
  endfunction

  function automatic void clear_slot_model();
    for (int i = 0; i < NUM_LAYERS; i++) begin
      slot_filled[i] = 1'b0;
      slot_tag[i]    = 32'h0;
    end
    victim_state = SEED_RESET;
  endfunction

  // Look up one patch, install it on a miss, and return the expected result
  function automatic slot_result_t predict_slot_lookup(input logic [15:0] x,
                                                       input logic [15:0] y);
    slot_result_t res;
    logic [31:0]  key;
    int           victim;
    key = {y, x};
    res = '0;
    for (int i = 0; i < NUM_LAYERS; i++) begin
      if (slot_filled[i] && slot_tag[i] == key) begin
        res.slot_index = i[7:0];
        return res;
      end
    end
    victim_state   = step_victim_lfsr(victim_state);
    victim         = victim_state % NUM_LAYERS;
    res.slot_index = victim[7:0];
    res.was_miss   = 1'b1;
    if (slot_filled[victim]) begin
      res.evicted_valid = 1'b1;
      res.evicted_x     = slot_tag[victim][15:0];
      res.evicted_y     = slot_tag[victim][31:16];
    end
    slot_filled[victim] = 1'b1;
    slot_tag[victim]    = key;
    return res;
  endfunction

  // Drive ready with random stall bursts, or hold it low for a requested stretch
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left = rx_stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
      rx_stall_left = $urandom_range(0, 4);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    slot_result_t seen;
    slot_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen = '{slot_index_o, was_miss_o, evicted_valid_o, evicted_x_o, evicted_y_o};
      result_count++;
      if (expected_slot_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d with nothing pending: slot %0d miss %0b evict %0b",
                   result_count, seen.slot_index, seen.was_miss, seen.evicted_valid);
      end else begin
        want = expected_slot_results.pop_front();
        if (seen.slot_index !== want.slot_index || seen.was_miss !== want.was_miss ||
            seen.evicted_valid !== want.evicted_valid ||
            seen.evicted_x !== want.evicted_x || seen.evicted_y !== want.evicted_y) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $write("result %0d: expected slot %0d miss %0b evict %0b (%0d,%0d),",
                   result_count, want.slot_index, want.was_miss, want.evicted_valid,
                   $signed(want.evicted_x), $signed(want.evicted_y));
            $display(" got slot %0d miss %0b evict %0b (%0d,%0d)",
                     seen.slot_index, seen.was_miss, seen.evicted_valid,
                     $signed(seen.evicted_x), $signed(seen.evicted_y));
          end
        end
      end
    end
  end

  // Offer one request and hold it until accepted, then record its expected result
  task automatic send_patch(input logic [15:0] x, input logic [15:0] y);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    patch_x_i  <= x;
    patch_y_i  <= y;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_slot_results.insert(expected_slot_results.size(), predict_slot_lookup(x, y));
  endtask

  // Send one request, sometimes after a short idle burst
  task automatic offer_patch(input logic [31:0] key);
    int gap;
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    send_patch(key[15:0], key[31:16]);
  endtask

  // Stop sending and wait until every pending result has arrived
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_slot_results.size() != 0) @(posedge clk_i);
  endtask

  // Load a new seed while the block is idle; zero falls back to the reset seed
  task automatic write_seed(input logic [15:0] seed);
    drain_results();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= seed;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    victim_state = (seed == 16'h0000) ? SEED_RESET : seed;
  endtask

  function automatic logic [15:0] corner_value();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void fill_key_pool();
    for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;
  endfunction

  // Mostly reuse keys from the working set, sometimes bring in new or corner keys
  function automatic logic [31:0] pick_key(input int pool_size);
    int          roll;
    logic [31:0] key;
    roll = $urandom_range(0, 99);
    if (roll < 70) return key_pool[$urandom_range(0, pool_size - 1)];
    if (roll < 90) begin
      key = $urandom;
      key_pool[$urandom_range(0, pool_size - 1)] = key;
      return key;
    end
    return {corner_value(), corner_value()};
  endfunction

  // Corner coordinates into empty slots, then look them up again as hits
  task automatic test_extreme_coords();
    logic [31:0] corners[8];
    corners = '{{16'h8000, 16'h8000}, {16'h7FFF, 16'h7FFF}, {16'h0000, 16'h0000},
                {16'hFFFF, 16'hFFFF}, {16'h7FFF, 16'h8000}, {16'h8000, 16'h7FFF},
                {16'hFFFE, 16'h0001}, {16'h5555, 16'hAAAA}};
    foreach (corners[i]) offer_patch(corners[i]);
    for (int i = 0; i < 4; i++) offer_patch(corners[i]);
  endtask

  // Zero, smallest and largest seeds, a few lookups after each
  task automatic test_seed_values();
    write_seed(16'h0000);
    offer_patch({16'h0000, 16'h0000});
    offer_patch({16'h1234, 16'h4321});
    write_seed(16'h0001);
    offer_patch({16'h0002, 16'hFFFD});
    offer_patch({16'h1234, 16'h4321});
    write_seed(16'hFFFF);
    offer_patch({16'h00FF, 16'hFF00});
    offer_patch({16'h7FFE, 16'h8001});
  endtask

  // Hold the receiver off for a long stretch while requests keep coming
  task automatic test_backpressure();
    drain_results();
    rx_hold_left = 3000;
    tx_gaps_on   = 1'b0;
    for (int i = 0; i < 16; i++) offer_patch(pick_key(64));
    tx_gaps_on   = 1'b1;
    drain_results();
  endtask

  // Random lookups over working sets smaller and larger than the cache
  task automatic test_random_lookups();
    int pool_sizes[6];
    pool_sizes = '{32, 128, 256, 400, 600, 1024};
    foreach (pool_sizes[p]) begin
      write_seed(16'($urandom_range(1, 65535)));
      fill_key_pool();
      for (int i = 0; i < 300; i++) offer_patch(pick_key(pool_sizes[p]));
    end
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_quiet_tail();
    write_seed(16'($urandom_range(1, 65535)));
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    fill_key_pool();
    for (int i = 0; i < 100; i++) offer_patch(pick_key(300));
  endtask

  initial begin
    clear_slot_model();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_extreme_coords();
    test_seed_values();
    test_backpressure();
    test_random_lookups();
    test_quiet_tail();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* patch_slot_cache_random_replace_core.f */
design/psc_pkg.sv
design/psc_cell.sv
design/psc_victim.sv
design/patch_slot_cache_random_replace_core.sv
verif/tb_patch_slot_cache_random_replace_core.sv
